// File: rtl/has_pkg.sv
// shared types and constants of the hit agreement statistics block
package has_pkg;

	localparam int DIST_FRAC_BITS = 32;
	localparam int REL_FRAC_BITS = 48;
	localparam int REL_W = REL_FRAC_BITS + 2;
	localparam int DIV_STEPS = REL_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W = 2;

	localparam logic [63:0] ABS_TOL_RESET =
		64'(((64'd1 << DIST_FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [63:0] REL_TOL_RESET = 64'd18446744;
	localparam logic [31:0] NONE_ID_RESET = 32'hffff_ffff;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ABS_TOL = 2'd0,
		CFG_REL_TOL = 2'd1,
		CFG_NONE_ID = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLS_MATCHED_MISS = 2'd0,
		CLS_HIT_MISS     = 2'd1,
		CLS_HIT_OK       = 2'd2,
		CLS_HIT_BAD      = 2'd3
	} item_class_t;

	typedef struct packed {
		logic               start_run;
		logic signed [31:0] surface_a;
		logic signed [31:0] surface_b;
		logic signed [63:0] dist_a;
		logic signed [63:0] dist_b;
		logic               finite_a;
		logic               finite_b;
	} has_in_t;

	typedef struct packed {
		logic [1:0]       item_class;
		logic             surface_mismatch;
		logic [63:0]      queries;
		logic [63:0]      both_hits;
		logic [63:0]      both_misses;
		logic [63:0]      hit_miss_splits;
		logic [63:0]      surface_disagreements;
		logic [63:0]      distance_disagreements;
		logic [63:0]      largest_absolute_difference;
		logic [REL_W-1:0] largest_relative_difference;
	} has_out_t;

	typedef struct packed {
		logic              capture;
		logic              prep;
		logic              scale;
		logic              div;
		logic              finish;
		logic [STEP_W-1:0] step;
	} has_cmd_t;

	typedef struct packed {
		logic need_dist;
	} has_sts_t;

endpackage

// File: rtl/hit_agreement_statistics.sv
// top level of the hit agreement statistics block
//
// Compares the answers of two ray-query engines item by item and keeps run
// statistics. Input channel in_valid/in_ready carries one has_in_t pair of
// results; output channel out_valid/out_ready returns one has_out_t with the
// item's class and every accumulator after that item. The config channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the absolute tolerance,
// the relative tolerance and the miss surface id; it is always ready and is
// meant to be written only while the block is idle.
// A matched finite hit passes from one input transaction to the next through
// capture, difference, scale, 50 steps of the restoring divider
// (the 64x64 tolerance product runs on one 32x32 multiplier during the
// first steps), then the finish step. Misses, hit/miss disagreements and
// non-finite hits skip the divider: capture, difference, then finish.
// The result sits in an output register; a new item is accepted while it
// waits, and the finish step holds until that register is free.
// Reset clears all statistics accumulators and loads the config register defaults.
module hit_agreement_statistics (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  has_pkg::has_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output has_pkg::has_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [has_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import has_pkg::*;

	has_cmd_t cmd;
	has_sts_t sts;

	assign cfg_ready = 1'b1;

	has_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	has_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

// File: rtl/has_ctrl.sv
// controller state machine: sequences capture, prep, divide and finish
module has_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  has_pkg::has_sts_t sts,
	output has_pkg::has_cmd_t cmd
);
	import has_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_SCALE = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              fin_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// result register must be free or emptying this cycle
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.prep    = (state_q == ST_PREP);
		cmd.scale   = (state_q == ST_SCALE);
		cmd.div     = (state_q == ST_DIV);
		cmd.finish  = fin_go;
		cmd.step    = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= sts.need_dist ? ST_SCALE : ST_FIN;
				end
				ST_SCALE: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= ST_FIN;
					step_q <= step_q + STEP_W'(1);
				end
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/has_datapath.sv
// datapath: config registers, difference, divider, multiplier and accumulators
module has_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [has_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data,
	input  has_pkg::has_in_t                in_data,
	input  has_pkg::has_cmd_t               cmd,
	output has_pkg::has_sts_t               sts,
	output has_pkg::has_out_t               out_data
);
	import has_pkg::*;

	logic [63:0] abs_tol_q;
	logic [63:0] rel_tol_q;
	logic [31:0] none_id_q;

	has_in_t      in_q;
	logic [63:0]  diff_q;
	logic [63:0]  mag_a_q;
	logic [63:0]  mag_b_q;
	logic [63:0]  scale_q;
	logic         over_abs_q;
	logic [63:0]  excess_q;
	logic [64:0]  rem_q;
	logic [REL_W-1:0] quo_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;

	logic [63:0]      queries_q, mhits_q, mmiss_q, hmiss_q, surf_q, dist_q;
	logic [63:0]      max_abs_q;
	logic [REL_W-1:0] max_rel_q;
	has_out_t         out_q;

	logic hit_a, hit_b, mh, mm, hm, nonfin, smis, bad, need_dist;
	logic [64:0] trial_sub;
	logic        ge;
	logic [63:0] rem_keep;
	logic [31:0] mul_x, mul_y;
	logic [63:0]      b_queries, b_mhits, b_mmiss, b_hmiss, b_surf, b_dist, b_max_abs;
	logic [REL_W-1:0] b_max_rel, rel;
	logic [63:0]      n_max_abs;
	logic [REL_W-1:0] n_max_rel;
	logic [1:0]       cls;

	assign hit_a     = (in_q.surface_a != none_id_q);
	assign hit_b     = (in_q.surface_b != none_id_q);
	assign mh        = hit_a && hit_b;
	assign mm        = !hit_a && !hit_b;
	assign hm        = hit_a ^ hit_b;
	assign nonfin    = mh && !(in_q.finite_a && in_q.finite_b);
	assign need_dist = mh && in_q.finite_a && in_q.finite_b;
	assign smis      = mh && (in_q.surface_a != in_q.surface_b);
	assign sts.need_dist = need_dist;

	// restoring divider step
	assign trial_sub = rem_q - {1'b0, scale_q};
	assign ge        = (rem_q >= {1'b0, scale_q});
	assign rem_keep  = ge ? trial_sub[63:0] : rem_q[63:0];

	// partial product operands, one 32x32 product per step
	always_comb begin
		case (cmd.step[1:0])
			2'd0: begin mul_x = rel_tol_q[31:0];  mul_y = scale_q[31:0];  end
			2'd1: begin mul_x = rel_tol_q[31:0];  mul_y = scale_q[63:32]; end
			2'd2: begin mul_x = rel_tol_q[63:32]; mul_y = scale_q[31:0];  end
			default: begin mul_x = rel_tol_q[63:32]; mul_y = scale_q[63:32]; end
		endcase
	end

	always_comb begin
		b_queries = in_q.start_run ? '0 : queries_q;
		b_mhits   = in_q.start_run ? '0 : mhits_q;
		b_mmiss   = in_q.start_run ? '0 : mmiss_q;
		b_hmiss   = in_q.start_run ? '0 : hmiss_q;
		b_surf    = in_q.start_run ? '0 : surf_q;
		b_dist    = in_q.start_run ? '0 : dist_q;
		b_max_abs = in_q.start_run ? '0 : max_abs_q;
		b_max_rel = in_q.start_run ? '0 : max_rel_q;
		rel       = (scale_q == '0) ? '0 : quo_q;
		bad       = nonfin || (need_dist && over_abs_q && (excess_q > acc_q[127:64]));

		if (nonfin) begin
			n_max_abs = '1;
			n_max_rel = '1;
		end else begin
			n_max_abs = (need_dist && diff_q > b_max_abs) ? diff_q : b_max_abs;
			n_max_rel = (need_dist && rel > b_max_rel) ? rel : b_max_rel;
		end

		if (hm)
			cls = CLS_HIT_MISS;
		else if (mm)
			cls = CLS_MATCHED_MISS;
		else if (bad)
			cls = CLS_HIT_BAD;
		else
			cls = CLS_HIT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_tol_q <= ABS_TOL_RESET;
			rel_tol_q <= REL_TOL_RESET;
			none_id_q <= NONE_ID_RESET;
			queries_q <= '0;
			mhits_q   <= '0;
			mmiss_q   <= '0;
			hmiss_q   <= '0;
			surf_q    <= '0;
			dist_q    <= '0;
			max_abs_q <= '0;
			max_rel_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ABS_TOL: abs_tol_q <= cfg_data;
					CFG_REL_TOL: rel_tol_q <= cfg_data;
					CFG_NONE_ID: none_id_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.finish) begin
				queries_q <= b_queries + 64'd1;
				mhits_q   <= b_mhits + 64'(mh);
				mmiss_q   <= b_mmiss + 64'(mm);
				hmiss_q   <= b_hmiss + 64'(hm);
				surf_q    <= b_surf + 64'(smis);
				dist_q    <= b_dist + 64'(bad);
				max_abs_q <= n_max_abs;
				max_rel_q <= n_max_rel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			in_q <= in_data;

		if (cmd.prep) begin
			if (in_q.dist_a >= in_q.dist_b)
				diff_q <= in_q.dist_a - in_q.dist_b;
			else
				diff_q <= in_q.dist_b - in_q.dist_a;
			mag_a_q <= in_q.dist_a[63] ? (~in_q.dist_a + 64'd1) : in_q.dist_a;
			mag_b_q <= in_q.dist_b[63] ? (~in_q.dist_b + 64'd1) : in_q.dist_b;
		end

		if (cmd.scale) begin
			scale_q    <= (mag_a_q > mag_b_q) ? mag_a_q : mag_b_q;
			rem_q      <= {2'b00, diff_q[63:1]};
			quo_q      <= '0;
			over_abs_q <= (diff_q > abs_tol_q);
			excess_q   <= diff_q - abs_tol_q;
			acc_q      <= '0;
		end

		if (cmd.div) begin
			// low bit of the numerator enters after the first step
			rem_q <= {rem_keep, (cmd.step == '0) ? diff_q[0] : 1'b0};
			quo_q <= {quo_q[REL_W-2:0], ge};
			if (cmd.step < STEP_W'(4))
				pp_q <= 64'(mul_x) * 64'(mul_y);
			case (cmd.step)
				STEP_W'(1): acc_q <= acc_q + {64'd0, pp_q};
				STEP_W'(2),
				STEP_W'(3): acc_q <= acc_q + {32'd0, pp_q, 32'd0};
				STEP_W'(4): acc_q <= acc_q + {pp_q, 64'd0};
				default: ;
			endcase
		end

		if (cmd.finish) begin
			out_q.item_class                  <= cls;
			out_q.surface_mismatch            <= smis;
			out_q.queries                     <= b_queries + 64'd1;
			out_q.both_hits                   <= b_mhits + 64'(mh);
			out_q.both_misses                 <= b_mmiss + 64'(mm);
			out_q.hit_miss_splits             <= b_hmiss + 64'(hm);
			out_q.surface_disagreements       <= b_surf + 64'(smis);
			out_q.distance_disagreements      <= b_dist + 64'(bad);
			out_q.largest_absolute_difference <= n_max_abs;
			out_q.largest_relative_difference <= n_max_rel;
		end
	end

	assign out_data = out_q;

endmodule
